FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL. Simulation builds get the checks;
// builds that define SYNTH get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int HUE_W  = 9;
  localparam int CH_W   = 8;
  localparam int R120_W = 7;
  localparam int WT_W   = 6;
  localparam int PROD_W = 2 * CH_W;
  localparam int Q_W    = CH_W + WT_W;

  // x = floor(q / 60) as (q * 17477) >> 20, exact for q below 23831.
  localparam int            RECIP_W     = 15;
  localparam logic [14:0]   RECIP_60    = 15'd17477;
  localparam int            RECIP_SHIFT = 20;
  localparam int            XPROD_W     = Q_W + RECIP_W;

  typedef logic [2:0] sector_t;

  // Sixty-degree hue sectors, named by the colors at their edges.
  localparam sector_t SEC_R_TO_Y = 3'd0;
  localparam sector_t SEC_Y_TO_G = 3'd1;
  localparam sector_t SEC_G_TO_C = 3'd2;
  localparam sector_t SEC_C_TO_B = 3'd3;
  localparam sector_t SEC_B_TO_M = 3'd4;
  localparam sector_t SEC_M_TO_R = 3'd5;

  typedef struct packed {
    sector_t           sector;
    logic [WT_W-1:0]   weight;
  } hue_info_t;

endpackage

FILE: sv/hsv2rgb_if.sv
interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue_deg;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  brightness;

  modport source (output valid, output hue_deg, output saturation,
                  output brightness, input ready);
  modport sink   (input valid, input hue_deg, input saturation,
                  input brightness, output ready);
endinterface

interface hsv2rgb_out_if import hsv2rgb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

FILE: sv/hsv2rgb_hue_decode.sv
// Splits a hue into its sector and the X weight 60 - |(hue mod 120) - 60|.
module hsv2rgb_hue_decode import hsv2rgb_pkg::*; (
  input  logic [HUE_W-1:0] hue_deg,
  output hue_info_t        info
);

  logic [HUE_W-1:0]  wrapped;
  logic [R120_W-1:0] r120;
  logic [R120_W-1:0] fold;

  always_comb begin
    if (hue_deg < HUE_W'(120)) begin
      wrapped = hue_deg;
    end else if (hue_deg < HUE_W'(240)) begin
      wrapped = hue_deg - HUE_W'(120);
    end else if (hue_deg < HUE_W'(360)) begin
      wrapped = hue_deg - HUE_W'(240);
    end else if (hue_deg < HUE_W'(480)) begin
      wrapped = hue_deg - HUE_W'(360);
    end else begin
      wrapped = hue_deg - HUE_W'(480);
    end
    r120 = wrapped[R120_W-1:0];

    if (r120 >= R120_W'(60)) begin
      fold = r120 - R120_W'(60);
    end else begin
      fold = R120_W'(60) - r120;
    end
    info.weight = WT_W'(R120_W'(60) - fold);

    // Hues of 300 and above, 360 and beyond included, share the last sector.
    if (hue_deg < HUE_W'(60)) begin
      info.sector = SEC_R_TO_Y;
    end else if (hue_deg < HUE_W'(120)) begin
      info.sector = SEC_Y_TO_G;
    end else if (hue_deg < HUE_W'(180)) begin
      info.sector = SEC_G_TO_C;
    end else if (hue_deg < HUE_W'(240)) begin
      info.sector = SEC_C_TO_B;
    end else if (hue_deg < HUE_W'(300)) begin
      info.sector = SEC_B_TO_M;
    end else begin
      info.sector = SEC_M_TO_R;
    end
  end

endmodule

FILE: sv/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter.
// pix_in carries one HSV pixel per transaction: hue in whole degrees (0..360,
// larger codes wrap by 120 and use the last sector) and 8-bit saturation and
// value, where 255 means 1.0. pix_out carries the matching 8-bit red, green
// and blue pixel, one transaction for every input transaction, in order.
// The datapath is a five-stage pipeline: hue decode and the S*V product,
// chroma by a divide-by-255 add-and-shift, the chroma times X-weight product,
// X by a reciprocal multiply for the divide by 60, and the channel select
// with the m offset added into the output register.
// An accepted pixel passes through the stage A, B, C and D registers before
// it is loaded into the output register. Throughput is one pixel per cycle
// while the receiver does not stall; the three multipliers, one of them by a
// constant, are each used once per pixel.
// Every stage carries a valid bit. All stages advance together whenever the
// output register is empty or being drained, so pix_in.ready follows
// pix_out.ready while the output holds a result. A stalled receiver freezes
// the whole pipeline; no transaction is dropped or repeated.
// Synchronous reset clears the valid bits; the data registers keep whatever
// they held, since no result is offered until new pixels arrive.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  hsv2rgb_in_if.sink          pix_in,
  hsv2rgb_out_if.source       pix_out
);

`include "assert_macros.svh"

  // Global advance: the output register is free or being read this cycle.
  logic advance;
  assign advance      = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = advance;

  hue_info_t hue_info;

  hsv2rgb_hue_decode u_hue_decode (
    .hue_deg (pix_in.hue_deg),
    .info    (hue_info)
  );

  // Stage A: sector, X weight, S*V product.
  logic              a_vld;
  sector_t           a_sec;
  logic [WT_W-1:0]   a_wt;
  logic [PROD_W-1:0] a_prod;
  logic [CH_W-1:0]   a_bright;

  // Stage B: chroma and the m offset.
  logic            b_vld;
  sector_t         b_sec;
  logic [WT_W-1:0] b_wt;
  logic [CH_W-1:0] b_chroma;
  logic [CH_W-1:0] b_m;

  // Stage C: chroma times weight.
  logic            c_vld;
  sector_t         c_sec;
  logic [CH_W-1:0] c_chroma;
  logic [CH_W-1:0] c_m;
  logic [Q_W-1:0]  c_q;

  // Stage D: X after the divide by 60.
  logic            d_vld;
  sector_t         d_sec;
  logic [CH_W-1:0] d_chroma;
  logic [CH_W-1:0] d_m;
  logic [CH_W-1:0] d_x;

  // The divide by 255 is exact for every S*V product, up to 255 * 255, as
  // (p + (p >> 8) + 1) >> 8.
  logic [PROD_W:0]    div255_sum;
  logic [CH_W-1:0]    chroma_next;
  logic [XPROD_W-1:0] x_prod;
  logic [CH_W-1:0]    x_next;

  assign div255_sum  = {1'b0, a_prod} + (PROD_W+1)'(a_prod[PROD_W-1:CH_W])
                       + (PROD_W+1)'(1);
  assign chroma_next = div255_sum[PROD_W-1:CH_W];
  assign x_prod      = XPROD_W'(c_q) * XPROD_W'(RECIP_60);
  assign x_next      = x_prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];

  logic [CH_W-1:0] red_sel;
  logic [CH_W-1:0] green_sel;
  logic [CH_W-1:0] blue_sel;

  always_comb begin
    case (d_sec)
      SEC_R_TO_Y: begin
        red_sel = d_chroma; green_sel = d_x;      blue_sel = '0;
      end
      SEC_Y_TO_G: begin
        red_sel = d_x;      green_sel = d_chroma; blue_sel = '0;
      end
      SEC_G_TO_C: begin
        red_sel = '0;       green_sel = d_chroma; blue_sel = d_x;
      end
      SEC_C_TO_B: begin
        red_sel = '0;       green_sel = d_x;      blue_sel = d_chroma;
      end
      SEC_B_TO_M: begin
        red_sel = d_x;      green_sel = '0;       blue_sel = d_chroma;
      end
      default: begin
        red_sel = d_chroma; green_sel = '0;       blue_sel = d_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld         <= 1'b0;
      b_vld         <= 1'b0;
      c_vld         <= 1'b0;
      d_vld         <= 1'b0;
      pix_out.valid <= 1'b0;
    end else if (advance) begin
      a_vld         <= pix_in.valid;
      b_vld         <= a_vld;
      c_vld         <= b_vld;
      d_vld         <= c_vld;
      pix_out.valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_sec    <= hue_info.sector;
      a_wt     <= hue_info.weight;
      a_prod   <= PROD_W'(pix_in.saturation) * PROD_W'(pix_in.brightness);
      a_bright <= pix_in.brightness;

      b_sec    <= a_sec;
      b_wt     <= a_wt;
      b_chroma <= chroma_next;
      b_m      <= a_bright - chroma_next;

      c_sec    <= b_sec;
      c_chroma <= b_chroma;
      c_m      <= b_m;
      c_q      <= Q_W'(b_chroma) * Q_W'(b_wt);

      d_sec    <= c_sec;
      d_chroma <= c_chroma;
      d_m      <= c_m;
      d_x      <= x_next;

      // C + m is the brightness and X never exceeds C, so no sum overflows.
      pix_out.red   <= red_sel + d_m;
      pix_out.green <= green_sel + d_m;
      pix_out.blue  <= blue_sel + d_m;
    end
  end

  `ASSERT_NEXT(a_load_on_accept, clk, rst, pix_in.valid && pix_in.ready, a_vld, "accepted pixel did not enter stage A")
  `ASSERT_NEXT(hold_on_stall, clk, rst, !advance, $stable({a_vld, b_vld, c_vld, d_vld}), "pipeline moved during a stall")
  `ASSERT_IMPLIES(x_within_chroma, clk, rst, d_vld, d_x <= d_chroma, "X exceeds chroma")
  `ASSERT_IMPLIES(weight_in_range, clk, rst, a_vld, a_wt <= WT_W'(60), "X weight above 60")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the HSV to RGB pixel converter.
//
// An initial block builds the whole pixel list up front: a short directed
// set that walks the sector edges and the extremes of saturation and value,
// followed by about 900 random pixels. A clocked driver feeds that list into
// pix_in with random gaps. A clocked monitor drains pix_out with random
// stalls and compares every result, field by field, against a queue of RGB
// values computed by a local integer model of the conversion.
module tb import hsv2rgb_pkg::*; ();

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_pixel_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_pixel_t;

  localparam int RANDOM_PIXELS = 900;
  // The monitor stops taking results once, partway through the run, for a
  // hold set by BACKPRESSURE_CYCLES, so that the pipeline backs up into pix_in.
  localparam int BACKPRESSURE_AT     = 400;
  localparam int BACKPRESSURE_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hsv2rgb_in_if  pix_in_bus ();
  hsv2rgb_out_if pix_out_bus ();

  hsv_to_rgb_converter i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_bus),
    .pix_out (pix_out_bus)
  );

  hsv_pixel_t  pending_hsv[$];
  rgb_pixel_t  expected_rgb[$];
  int unsigned pixels_total    = 0;
  int unsigned pixels_accepted = 0;
  int unsigned results_seen    = 0;
  int unsigned error_count     = 0;

  // Driver and monitor bookkeeping. Each variable is touched by one process.
  hsv_pixel_t  next_px;
  rgb_pixel_t  want_rgb;
  int unsigned send_idle  = 0;
  int unsigned send_calm  = 0;
  int unsigned recv_idle  = 0;
  int unsigned recv_calm  = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Known values on every block input before the first clock edge.
  initial begin
    pix_in_bus.valid      = 1'b0;
    pix_in_bus.hue_deg    = '0;
    pix_in_bus.saturation = '0;
    pix_in_bus.brightness = '0;
    pix_out_bus.ready     = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Which sixty-degree slice a hue falls in. Anything at or above 300,
  // including 360 and the out-of-range codes up to 511, lands in the last one.
  function automatic sector_t hue_sector(logic [HUE_W-1:0] hue);
    if (hue < 60)  return SEC_R_TO_Y;
    if (hue < 120) return SEC_Y_TO_G;
    if (hue < 180) return SEC_G_TO_C;
    if (hue < 240) return SEC_C_TO_B;
    if (hue < 300) return SEC_B_TO_M;
    return SEC_M_TO_R;
  endfunction

  // Integer HSV to RGB with truncating divides at every step.
  function automatic rgb_pixel_t hsv_to_rgb(hsv_pixel_t px);
    int unsigned chroma, hue_mod, fold, x_part, offset;
    int unsigned r_part, g_part, b_part;
    rgb_pixel_t  rgb;
    chroma  = (int'(px.sat) * int'(px.val)) / 255;
    hue_mod = int'(px.hue) % 120;
    fold    = (hue_mod >= 60) ? hue_mod - 60 : 60 - hue_mod;
    x_part  = (chroma * (60 - fold)) / 60;
    offset  = int'(px.val) - chroma;
    case (hue_sector(px.hue))
      SEC_R_TO_Y: begin r_part = chroma; g_part = x_part; b_part = 0;      end
      SEC_Y_TO_G: begin r_part = x_part; g_part = chroma; b_part = 0;      end
      SEC_G_TO_C: begin r_part = 0;      g_part = chroma; b_part = x_part; end
      SEC_C_TO_B: begin r_part = 0;      g_part = x_part; b_part = chroma; end
      SEC_B_TO_M: begin r_part = x_part; g_part = 0;      b_part = chroma; end
      default:    begin r_part = chroma; g_part = 0;      b_part = x_part; end
    endcase
    rgb.red   = CH_W'(r_part + offset);
    rgb.green = CH_W'(g_part + offset);
    rgb.blue  = CH_W'(b_part + offset);
    return rgb;
  endfunction

  // Idle length between transactions: mostly none, some short, a few long.
  // Once in a while a stretch of back-to-back transactions is forced
  // through the calm counter.
  function automatic int unsigned pick_gap(ref int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 4) begin
      calm = $urandom_range(80, 30);
      return 0;
    end
    if (roll < 62) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [CH_W-1:0] pick_channel();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8)  return '0;
    if (roll < 16) return '1;
    return CH_W'($urandom_range(255));
  endfunction

  task automatic queue_pixel(int unsigned hue, int unsigned sat, int unsigned val);
    hsv_pixel_t px;
    px.hue = HUE_W'(hue);
    px.sat = CH_W'(sat);
    px.val = CH_W'(val);
    pending_hsv.push_back(px);
  endtask

  // Stimulus list.
  initial begin
    hsv_pixel_t px;
    int unsigned roll;
    // Sector edges at full saturation and value: pure primaries and
    // secondaries, plus the last degree of every sector.
    queue_pixel(0, 255, 255);
    queue_pixel(59, 255, 255);
    queue_pixel(60, 255, 255);
    queue_pixel(119, 255, 255);
    queue_pixel(120, 255, 255);
    queue_pixel(179, 255, 255);
    queue_pixel(180, 255, 255);
    queue_pixel(239, 255, 255);
    queue_pixel(240, 255, 255);
    queue_pixel(299, 255, 255);
    queue_pixel(300, 255, 255);
    queue_pixel(359, 255, 255);
    // A full circle of 360 degrees: X drops to zero in the last sector.
    queue_pixel(360, 200, 180);
    // Zero saturation gives gray, zero value gives black.
    queue_pixel(90, 0, 170);
    queue_pixel(210, 255, 0);
    queue_pixel(30, 0, 0);
    queue_pixel(150, 1, 1);
    queue_pixel(270, 128, 255);
    queue_pixel(330, 255, 128);
    // Codes above 360 wrap by 120 but stay in the last sector.
    queue_pixel(361, 255, 255);
    queue_pixel(420, 170, 200);
    queue_pixel(511, 255, 255);
    queue_pixel(256, 99, 77);

    repeat (RANDOM_PIXELS) begin
      roll = $urandom_range(99);
      if (roll < 5)
        px.hue = HUE_W'($urandom_range(511, 361));
      else if (roll < 15)
        px.hue = HUE_W'(60 * $urandom_range(6));
      else
        px.hue = HUE_W'($urandom_range(360));
      px.sat = pick_channel();
      px.val = pick_channel();
      pending_hsv.push_back(px);
    end
    pixels_total = pending_hsv.size();
  end

  // Driver. The expected result is computed at the accepting edge from the
  // payload that was actually on the bus.
  always @(posedge clk) begin
    if (rst) begin
      pix_in_bus.valid <= 1'b0;
    end else begin
      if (pix_in_bus.valid && pix_in_bus.ready) begin
        next_px.hue = pix_in_bus.hue_deg;
        next_px.sat = pix_in_bus.saturation;
        next_px.val = pix_in_bus.brightness;
        expected_rgb.push_back(hsv_to_rgb(next_px));
        pixels_accepted++;
      end
      // A new pixel goes out only once the current one has been taken.
      if (!pix_in_bus.valid || pix_in_bus.ready) begin
        if (send_idle > 0) begin
          send_idle--;
          pix_in_bus.valid <= 1'b0;
        end else if (pending_hsv.size() == 0) begin
          pix_in_bus.valid <= 1'b0;
        end else begin
          next_px = pending_hsv.pop_front();
          pix_in_bus.hue_deg    <= next_px.hue;
          pix_in_bus.saturation <= next_px.sat;
          pix_in_bus.brightness <= next_px.val;
          pix_in_bus.valid      <= 1'b1;
          send_idle = pick_gap(send_calm);
        end
      end
    end
  end

  // Monitor. Results are checked at the accepting edge; ready for the next
  // cycle is then chosen from the stall counters.
  always @(posedge clk) begin
    if (rst) begin
      pix_out_bus.ready <= 1'b0;
    end else begin
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        results_seen++;
        if (expected_rgb.size() == 0) begin
          error_count++;
          $display("%0t: unexpected pixel out, got r=%0d g=%0d b=%0d", $time,
                   pix_out_bus.red, pix_out_bus.green, pix_out_bus.blue);
        end else begin
          want_rgb = expected_rgb.pop_front();
          if (pix_out_bus.red !== want_rgb.red) begin
            error_count++;
            $display("%0t: red expected %0d, got %0d", $time, want_rgb.red,
                     pix_out_bus.red);
          end
          if (pix_out_bus.green !== want_rgb.green) begin
            error_count++;
            $display("%0t: green expected %0d, got %0d", $time, want_rgb.green,
                     pix_out_bus.green);
          end
          if (pix_out_bus.blue !== want_rgb.blue) begin
            error_count++;
            $display("%0t: blue expected %0d, got %0d", $time, want_rgb.blue,
                     pix_out_bus.blue);
          end
        end
        recv_idle = pick_gap(recv_calm);
        // One long hold-off while the driver keeps offering pixels.
        if (!hold_done && results_seen == BACKPRESSURE_AT) begin
          hold_done = 1'b1;
          hold_left = BACKPRESSURE_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_bus.ready <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle--;
        pix_out_bus.ready <= 1'b0;
      end else begin
        pix_out_bus.ready <= 1'b1;
      end
    end
  end

  // End of run: every pixel taken and every result seen, then a last wait in
  // which stray results are still caught.
  initial begin
    @(negedge rst);
    while (pixels_total == 0 || pixels_accepted < pixels_total ||
           expected_rgb.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
